>>> sv/fte_pkg.sv
package fte_pkg;

  // default table size and configuration address width
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int ADDR_W            = 4;

  localparam logic [15:0] ENTRY_FREE    = 16'h0000;
  localparam logic [15:0] ENTRY_END     = 16'hFFFF;
  localparam logic [15:0] CHAIN_END_MIN = 16'hFFF8;
  localparam int          SECTOR_SHIFT  = 8;  // 256 entries per fat sector

  // register reset values
  localparam logic [4:0]  FAT_SECTORS_RESET = 5'd16;
  localparam logic [31:0] DATA_START_RESET  = 32'd0;
  localparam logic [7:0]  SEC_PER_CL_RESET  = 8'd1;

  typedef enum logic [1:0] {
    REG_FAT_SECTORS = 2'd0,
    REG_DATA_START  = 2'd1,
    REG_SEC_PER_CL  = 2'd2
  } fte_reg_t;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_ALLOCATE  = 3'd2,
    OP_FREE      = 3'd3,
    OP_TO_SECTOR = 3'd4
  } fte_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2
  } fte_status_t;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_RDATA = 2'd1,
    RES_SCAN  = 2'd2
  } fte_res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        clear_step;
    logic        latch;
    logic        rd_cl;
    logic        wr_cl;
    logic        scan_init;
    logic        scan;
    logic        walk_init;
    logic        walk;
    logic        mul;
    logic        finish;
    fte_res_t    res_sel;
    logic        addr_en;
    fte_status_t st;
    logic        load_out;
  } fte_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       cl_in_table;
    logic       cl_low;
    logic       clear_last;
    logic       scan_found;
    logic       scan_more;
    logic       walk_end;
    logic       walk_range;
  } fte_stat_t;

endpackage

>>> sv/fte_datapath.sv
module fte_datapath #(
  parameter int TABLE_ENTRIES = fte_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  fte_pkg::fte_cmd_t cmd,
  output fte_pkg::fte_stat_t stat,
  input  logic [2:0]        operation,
  input  logic [15:0]       cluster,
  input  logic [15:0]       value,
  input  logic [4:0]        fat_sectors,
  input  logic [31:0]       data_start,
  input  logic [7:0]        sec_per_cl,
  output logic [15:0]       result_cluster,
  output logic [31:0]       sector_address,
  output logic [1:0]        status
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [16:0] TE17 = 17'(TABLE_ENTRIES);

  // table storage
  logic [15:0] mem [TABLE_ENTRIES];
  logic [15:0] mem_q;
  logic        fwd_q;
  logic [15:0] wdata_q;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] waddr, raddr;
  logic [15:0]      wdata;
  logic [15:0]      rdata;

  // request, scan, walk, address and result registers
  logic [2:0]       op_q;
  logic [15:0]      cl_q, val_q;
  logic [IDX_W-1:0] clr_q;
  logic [CNT_W-1:0] scan_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             pend_q;
  logic [15:0]      cur_q;
  logic [CNT_W-1:0] steps_q;
  logic             first_q;
  logic [31:0]      prod_q;
  logic [15:0]      res_q;
  logic [31:0]      addr_q;
  logic [1:0]       st_q;

  logic [16:0] lim17, sec_lim;
  logic [15:0] link;
  logic        scan_found, scan_more, walk_end, walk_range;
  logic [31:0] diff;

  assign rdata      = fwd_q ? wdata_q : mem_q;
  assign sec_lim    = {4'b0, fat_sectors, 8'b0};
  assign lim17      = (sec_lim < TE17) ? sec_lim : TE17;
  assign scan_found = pend_q && (rdata == fte_pkg::ENTRY_FREE);
  assign scan_more  = 17'(scan_q) < lim17;
  assign link       = first_q ? cur_q : rdata;
  assign walk_end   = link >= fte_pkg::CHAIN_END_MIN;
  assign walk_range = !({1'b0, link} < TE17) || (17'(steps_q) >= TE17);
  assign diff       = 32'(cl_q) - 32'd2;

  assign stat.op          = op_q;
  assign stat.cl_in_table = {1'b0, cl_q} < TE17;
  assign stat.cl_low      = cl_q < 16'd2;
  assign stat.clear_last  = clr_q == IDX_W'(TABLE_ENTRIES - 1);
  assign stat.scan_found  = scan_found;
  assign stat.scan_more   = scan_more;
  assign stat.walk_end    = walk_end;
  assign stat.walk_range  = walk_range;

  // memory port selection
  always_comb begin
    wr_en = 1'b0;
    waddr = cl_q[IDX_W-1:0];
    wdata = fte_pkg::ENTRY_FREE;
    rd_en = 1'b0;
    raddr = cl_q[IDX_W-1:0];
    if (cmd.clear_step) begin
      wr_en = 1'b1;
      waddr = clr_q;
    end else if (cmd.wr_cl) begin
      wr_en = 1'b1;
      wdata = val_q;
    end else if (cmd.rd_cl) begin
      rd_en = 1'b1;
    end else if (cmd.scan) begin
      if (scan_found) begin
        wr_en = 1'b1;
        waddr = rd_idx_q;
        wdata = fte_pkg::ENTRY_END;
      end else if (scan_more) begin
        rd_en = 1'b1;
        raddr = scan_q[IDX_W-1:0];
      end
    end else if (cmd.walk) begin
      // zero the entry read last cycle, fetch the next link
      wr_en = !first_q;
      waddr = cur_q[IDX_W-1:0];
      if (!walk_end && !walk_range) begin
        rd_en = 1'b1;
        raddr = link[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) mem_q <= mem[raddr];
    fwd_q   <= rd_en && wr_en && (raddr == waddr);
    wdata_q <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_q <= clr_q + IDX_W'(1);
      if (cmd.scan_init) begin
        pend_q <= 1'b0;
      end else if (cmd.scan) begin
        pend_q <= !scan_found && scan_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= operation;
      cl_q  <= cluster;
      val_q <= value;
    end
    if (cmd.scan_init) begin
      scan_q <= CNT_W'(2);
    end else if (cmd.scan && !scan_found && scan_more) begin
      scan_q   <= scan_q + CNT_W'(1);
      rd_idx_q <= scan_q[IDX_W-1:0];
    end
    if (cmd.walk_init) begin
      cur_q   <= cl_q;
      steps_q <= '0;
      first_q <= 1'b1;
    end else if (cmd.walk && !walk_end && !walk_range) begin
      cur_q   <= link;
      steps_q <= steps_q + CNT_W'(1);
      first_q <= 1'b0;
    end
    if (cmd.mul) prod_q <= 32'(diff * {24'b0, sec_per_cl});
    if (cmd.finish) begin
      case (cmd.res_sel)
        fte_pkg::RES_RDATA: res_q <= rdata;
        fte_pkg::RES_SCAN:  res_q <= 16'(rd_idx_q);
        default:            res_q <= 16'd0;
      endcase
      addr_q <= cmd.addr_en ? data_start + prod_q : 32'd0;
      st_q   <= cmd.st;
    end
    if (cmd.load_out) begin
      result_cluster <= res_q;
      sector_address <= addr_q;
      status         <= st_q;
    end
  end

  // a found entry is marked without a fetch in the same cycle
  a_scan_no_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && scan_found |-> wr_en && !rd_en)
    else $error("scan fetched while marking");

  // every walk step after the first zeroes an entry
  a_walk_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.walk && !first_q |-> wr_en && (wdata == fte_pkg::ENTRY_FREE))
    else $error("walk step without zeroing");

endmodule

>>> sv/fte_ctrl.sv
module fte_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fte_pkg::fte_cmd_t   cmd,
  input  fte_pkg::fte_stat_t  stat
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_RDWAIT = 8'b0000_1000,
    S_ADDS   = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_WALK   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        cmd.finish = 1'b1;
        cmd.st     = fte_pkg::ST_OK;
        case (stat.op)
          fte_pkg::OP_READ: begin
            if (stat.cl_in_table) begin
              cmd.finish = 1'b0;
              cmd.rd_cl  = 1'b1;
              state_next = S_RDWAIT;
            end else begin
              cmd.st = fte_pkg::ST_RANGE;
            end
          end
          fte_pkg::OP_WRITE: begin
            if (stat.cl_in_table) cmd.wr_cl = 1'b1;
            else cmd.st = fte_pkg::ST_RANGE;
          end
          fte_pkg::OP_ALLOCATE: begin
            cmd.finish    = 1'b0;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          fte_pkg::OP_FREE: begin
            if (!stat.cl_low) begin
              cmd.finish    = 1'b0;
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          fte_pkg::OP_TO_SECTOR: begin
            cmd.finish = 1'b0;
            cmd.mul    = 1'b1;
            state_next = S_ADDS;
          end
          default: begin
            cmd.st = fte_pkg::ST_RANGE;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = fte_pkg::RES_RDATA;
        state_next  = S_RESP;
      end
      S_ADDS: begin
        cmd.finish  = 1'b1;
        cmd.addr_en = 1'b1;
        cmd.st      = stat.cl_in_table ? fte_pkg::ST_OK : fte_pkg::ST_RANGE;
        state_next  = S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_found) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = fte_pkg::RES_SCAN;
          state_next  = S_RESP;
        end else if (!stat.scan_more) begin
          cmd.finish = 1'b1;
          cmd.st     = fte_pkg::ST_NOFREE;
          state_next = S_RESP;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_end) begin
          cmd.finish = 1'b1;
          state_next = S_RESP;
        end else if (stat.walk_range) begin
          cmd.finish = 1'b1;
          cmd.st     = fte_pkg::ST_RANGE;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_ready) rsp_valid_next = 1'b0;
    if (cmd.load_out) rsp_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_EXEC)
    else $error("accepted transaction not executed");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("result loaded without valid");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && rsp_valid && !rsp_ready |=> state == S_RESP)
    else $error("waiting result overwritten");

endmodule

>>> sv/fat16_table_engine.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+-------------------------------------------
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
// request   | req_valid, req_ready          | operation, cluster, value
// response  | rsp_valid, rsp_ready          | result_cluster, sector_address, status
//
// one transaction at a time through a single-port-write table memory
// write, unknown code, read out of range, free from a reserved cluster: finish at dispatch
// read: table fetch, then result; cluster to sector: multiply then add
// allocate: probes entries in turn, one entry a cycle; free: walks and zeroes the chain
// after reset a clearing pass zeroes every table entry, req_ready low
// the response register lets a new request in while a result waits for rsp_ready
module fat16_table_engine #(
  parameter int TABLE_ENTRIES = fte_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fte_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // request channel
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [2:0]                operation,
  input  logic [15:0]               cluster,
  input  logic [15:0]               value,
  // response channel
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic [15:0]               result_cluster,
  output logic [31:0]               sector_address,
  output logic [1:0]                status
);

  fte_pkg::fte_cmd_t  cmd;
  fte_pkg::fte_stat_t stat;

  // configuration registers
  logic [4:0]  fat_sectors;
  logic [31:0] data_start;
  logic [7:0]  sec_per_cl;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_sectors <= fte_pkg::FAT_SECTORS_RESET;
      data_start  <= fte_pkg::DATA_START_RESET;
      sec_per_cl  <= fte_pkg::SEC_PER_CL_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        fte_pkg::REG_FAT_SECTORS: fat_sectors <= pwdata[4:0];
        fte_pkg::REG_DATA_START:  data_start  <= pwdata;
        fte_pkg::REG_SEC_PER_CL:  sec_per_cl  <= pwdata[7:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  // read back, zero-extended
  always_comb begin
    case (reg_idx)
      fte_pkg::REG_FAT_SECTORS: prdata = {27'd0, fat_sectors};
      fte_pkg::REG_DATA_START:  prdata = data_start;
      fte_pkg::REG_SEC_PER_CL:  prdata = {24'd0, sec_per_cl};
      default:                  prdata = 32'd0;
    endcase
  end

  // sequencing: clear pass, dispatch, scan and walk loops, response hand-off
  fte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // table memory, scan and chain registers, address arithmetic, result registers
  fte_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .cluster        (cluster),
    .value          (value),
    .fat_sectors    (fat_sectors),
    .data_start     (data_start),
    .sec_per_cl     (sec_per_cl),
    .result_cluster (result_cluster),
    .sector_address (sector_address),
    .status         (status)
  );

endmodule
